@@ src/fmm_pkg.sv @@
package fmm_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_LOAD_L  = 2'd0;
    localparam logic [1:0] ACT_LOAD_R  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // Control flags that travel with a term through a cell
    typedef struct packed {
        logic valid;
        logic first;  // first term of a dot product: load the accumulator
        logic raw;    // add the stored right element unscaled
        logic last;   // final term of the row
    } flg_t;

    // Term handed from cell to cell along the row
    typedef struct packed {
        flg_t        f;
        logic [1:0]  k;
        logic [31:0] lval;
    } tok_t;

endpackage

@@ src/fp_matrix_multiply_4x4_top.sv @@
// Single-precision 4x4 matrix multiplier, P = L * R.
// Input channel (s_*): each word carries an action. Load-left and load-right
// write one row (s_row_index) from s_elem0..s_elem3; they return nothing.
// Compute returns four words on the m_* channel, rows 0..3 in order, with
// m_last_row high on row 3. Action 3 is dropped.
// Configuration (cfg_*): one bit, affine mode; left column 3 reads as 0,0,0,1.
// Four cells, one per result column, each with a multiplier and an adder; the
// left element of each term ripples one cell per cycle. Terms enter spaced
// apart, bounded by the accumulate loop inside a cell.
// A row starts at the handshake of the compute word or of the previous result
// word and issues 4 terms, or 3 in affine mode (4 for affine row 3). The next
// row starts once the current one is taken; s_ready stays low for the whole
// compute, receiver stall time included.
// Reset clears control and affine mode; matrix contents stay undefined until
// loaded. When m_ready is low the result word holds and the block waits.
module fp_matrix_multiply_4x4_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [1:0]  s_row_index,
    input  logic [31:0] s_elem0,
    input  logic [31:0] s_elem1,
    input  logic [31:0] s_elem2,
    input  logic [31:0] s_elem3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_row,
    output logic [31:0] m_prod0,
    output logic [31:0] m_prod1,
    output logic [31:0] m_prod2,
    output logic [31:0] m_prod3,
    output logic        m_last_row,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import fmm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t      state_reg;
    logic        affine_reg;
    logic [31:0] left_reg [16];
    logic [1:0]  row_reg;
    logic [1:0]  step_reg;
    logic        gap_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        m_valid_reg;
    logic [31:0] m_prod_reg [4];

    logic [31:0] elem [4];
    tok_t        chain [5];
    logic [31:0] res [4];
    logic [3:0]  done;

    logic        s_accept;
    logic        rload;
    logic [1:0]  last_step;

    assign elem[0] = s_elem0;
    assign elem[1] = s_elem1;
    assign elem[2] = s_elem2;
    assign elem[3] = s_elem3;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign rload     = s_accept && (s_action == ACT_LOAD_R);
    assign last_step = (affine_reg && (row_reg != 2'd3)) ? 2'd2 : 2'd3;

    // Build the next term for the row of cells
    always_comb begin
        tok_next = '0;
        if ((state_reg == ST_ISSUE) && !gap_reg) begin
            tok_next.f.valid = 1'b1;
            tok_next.f.first = (step_reg == 2'd0);
            tok_next.f.last  = (step_reg == last_step);
            tok_next.f.raw   = affine_reg && (row_reg == 2'd3) && (step_reg == 2'd3);
            tok_next.k       = step_reg;
            tok_next.lval    = left_reg[{row_reg, step_reg}];
        end
    end

    // Sequence loads, term issue and row delivery
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            affine_reg  <= 1'b0;
            gap_reg     <= 1'b0;
            tok_reg.f   <= '0;
            m_valid_reg <= 1'b0;
            row_reg     <= 2'd0;
            step_reg    <= 2'd0;
        end else begin
            tok_reg <= tok_next;
            if (cfg_valid && cfg_ready) begin
                affine_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_action == ACT_COMPUTE)) begin
                        state_reg <= ST_ISSUE;
                        row_reg   <= 2'd0;
                        step_reg  <= 2'd0;
                        gap_reg   <= 1'b0;
                    end
                end
                ST_ISSUE: begin
                    gap_reg <= !gap_reg;
                    if (!gap_reg) begin
                        if (step_reg == last_step) begin
                            state_reg <= ST_WAIT;
                        end else begin
                            step_reg <= step_reg + 2'd1;
                        end
                    end
                end
                ST_WAIT: begin
                    if (done[3]) begin
                        state_reg   <= ST_OUT;
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (row_reg == 2'd3) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_ISSUE;
                            row_reg   <= row_reg + 2'd1;
                            step_reg  <= 2'd0;
                            gap_reg   <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Left matrix rows and result capture
    always_ff @(posedge aclk) begin
        if (s_accept && (s_action == ACT_LOAD_L)) begin
            for (int j = 0; j < 4; j++) begin
                left_reg[{s_row_index, 2'(j)}] <= elem[j];
            end
        end
        if ((state_reg == ST_WAIT) && done[3]) begin
            for (int j = 0; j < 4; j++) begin
                m_prod_reg[j] <= res[j];
            end
        end
    end

    assign chain[0] = tok_reg;

    // Row of multiply-accumulate cells, one per column
    for (genvar j = 0; j < 4; j++) begin : g_cell
        fmm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tok_in    (chain[j]),
            .tok_out   (chain[j+1]),
            .rload     (rload),
            .rrow      (s_row_index),
            .rdata     (elem[j]),
            .result    (res[j]),
            .done_last (done[j])
        );
    end

    assign m_valid    = m_valid_reg;
    assign m_out_row  = row_reg;
    assign m_last_row = (row_reg == 2'd3);
    assign m_prod0    = m_prod_reg[0];
    assign m_prod1    = m_prod_reg[1];
    assign m_prod2    = m_prod_reg[2];
    assign m_prod3    = m_prod_reg[3];

    ap_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result word is pending");

    ap_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_row) |=> s_ready)
        else $error("block not idle after last row");

    ap_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_action == ACT_COMPUTE)) |=> !s_ready)
        else $error("compute did not start");

    ap_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        done[3] |-> (state_reg == ST_WAIT))
        else $error("row finished outside wait");

endmodule

@@ src/fmm_cell.sv @@
module fmm_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  fmm_pkg::tok_t tok_in,
    output fmm_pkg::tok_t tok_out,
    input  logic          rload,
    input  logic [1:0]    rrow,
    input  logic [31:0]   rdata,
    output logic [31:0]   result,
    output logic          done_last
);
    import fmm_pkg::*;

    localparam logic [31:0] QNAN = 32'hFFC0_0000;
    localparam logic [31:0] QBIT = 32'h0040_0000;

    // Count leading zeros of a 24-bit mantissa
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    // Count leading zeros of a 27-bit sum
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    // Round to nearest even and pack; mm is {mantissa, guard, sticky}
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [25:0] mm);
        logic [11:0] sh;
        logic [4:0]  shc;
        logic [51:0] w;
        logic [23:0] m;
        logic        g;
        logic        st;
        logic        up;
        logic [24:0] mr;
        logic [11:0] ef;
        logic [35:0] tot;
        sh  = (e <= 0) ? 12'(12'sd1 - e) : 12'd0;
        shc = (sh > 12'd26) ? 5'd26 : sh[4:0];
        w   = {mm, 26'b0} >> shc;
        m   = w[51:28];
        g   = w[27];
        st  = |w[26:0];
        up  = g & (st | m[0]);
        mr  = {1'b0, m} + {24'b0, up};
        ef  = (e <= 0) ? 12'd1 : e;
        tot = {1'b0, ef - 12'd1, 23'b0} + {11'b0, mr};
        if (tot >= {1'b0, 12'd255, 23'b0}) return {s, 8'hFF, 23'b0};
        return {s, tot[30:0]};
    endfunction

    // Right matrix column held by this cell
    logic [31:0] rcol_reg [4];
    tok_t        tok_out_reg;

    flg_t        fa_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;

    flg_t               f1_reg;
    logic               sp1_reg;
    logic [31:0]        spv1_reg;
    logic               sg1_reg;
    logic [23:0]        ma1_reg;
    logic [23:0]        mb1_reg;
    logic signed [9:0]  ea1_reg;
    logic signed [9:0]  eb1_reg;

    flg_t               f2_reg;
    logic               sp2_reg;
    logic [31:0]        spv2_reg;
    logic               sg2_reg;
    logic [47:0]        p2_reg;
    logic signed [11:0] e2_reg;

    flg_t               f3_reg;
    logic [31:0]        prod3_reg;

    flg_t               f4_reg;
    logic               pass4_reg;
    logic [31:0]        v4_reg;
    logic               sub4_reg;
    logic               sgn4_reg;
    logic [7:0]         e4_reg;
    logic [26:0]        mb4_reg;
    logic [26:0]        ms4_reg;

    logic [31:0]        acc_reg;
    logic               done_reg;

    // Stage 1: unpack, catch special operands and raw terms, prenormalize subnormals
    logic               sp1_next;
    logic [31:0]        spv1_next;
    logic [23:0]        ma_raw;
    logic [23:0]        mb_raw;
    logic [4:0]         lza;
    logic [4:0]         lzb;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, psign;

    always_comb begin
        a_nan  = (&a_reg[30:23]) && (|a_reg[22:0]);
        b_nan  = (&b_reg[30:23]) && (|b_reg[22:0]);
        a_inf  = (&a_reg[30:23]) && !(|a_reg[22:0]);
        b_inf  = (&b_reg[30:23]) && !(|b_reg[22:0]);
        a_zero = !(|a_reg[30:0]);
        b_zero = !(|b_reg[30:0]);
        psign  = a_reg[31] ^ b_reg[31];
        ma_raw = {|a_reg[30:23], a_reg[22:0]};
        mb_raw = {|b_reg[30:23], b_reg[22:0]};
        lza    = lzc24(ma_raw);
        lzb    = lzc24(mb_raw);
        sp1_next  = 1'b1;
        spv1_next = '0;
        priority if (fa_reg.raw) begin
            spv1_next = b_reg;
        end else if (a_nan) begin
            spv1_next = a_reg | QBIT;
        end else if (b_nan) begin
            spv1_next = b_reg | QBIT;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            spv1_next = QNAN;
        end else if (a_inf || b_inf) begin
            spv1_next = {psign, 8'hFF, 23'b0};
        end else if (a_zero || b_zero) begin
            spv1_next = {psign, 31'b0};
        end else begin
            sp1_next = 1'b0;
        end
    end

    // Stage 3: normalize the product and round
    logic [25:0]        mm3;
    logic signed [11:0] e3;

    always_comb begin
        if (p2_reg[47]) begin
            mm3 = {p2_reg[47:24], p2_reg[23], |p2_reg[22:0]};
            e3  = e2_reg + 12'sd1;
        end else begin
            mm3 = {p2_reg[46:23], p2_reg[22], |p2_reg[21:0]};
            e3  = e2_reg;
        end
    end

    // Stage 4: order the operands by magnitude, align the smaller one, catch specials
    logic               x_nan, y_nan, x_inf, y_inf, swp;
    logic               pass4_next;
    logic [31:0]        v4_next;
    logic [31:0]        big;
    logic [31:0]        sml;
    logic [7:0]         ebig;
    logic [7:0]         esml;
    logic [7:0]         dexp;
    logic [4:0]         dcl;
    logic [53:0]        wal;
    logic [26:0]        msh;

    always_comb begin
        x_nan = (&acc_reg[30:23]) && (|acc_reg[22:0]);
        y_nan = (&prod3_reg[30:23]) && (|prod3_reg[22:0]);
        x_inf = (&acc_reg[30:23]) && !(|acc_reg[22:0]);
        y_inf = (&prod3_reg[30:23]) && !(|prod3_reg[22:0]);
        swp   = prod3_reg[30:0] > acc_reg[30:0];
        big   = swp ? prod3_reg : acc_reg;
        sml   = swp ? acc_reg : prod3_reg;
        ebig  = (|big[30:23]) ? big[30:23] : 8'd1;
        esml  = (|sml[30:23]) ? sml[30:23] : 8'd1;
        dexp  = ebig - esml;
        dcl   = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
        wal   = {|sml[30:23], sml[22:0], 3'b0, 27'b0} >> dcl;
        msh   = {wal[53:28], wal[27] | (|wal[26:0])};
        pass4_next = 1'b1;
        v4_next    = '0;
        priority if (f3_reg.first) begin
            v4_next = prod3_reg;
        end else if (x_nan) begin
            v4_next = acc_reg | QBIT;
        end else if (y_nan) begin
            v4_next = prod3_reg | QBIT;
        end else if (x_inf && y_inf && (acc_reg[31] != prod3_reg[31])) begin
            v4_next = QNAN;
        end else if (x_inf) begin
            v4_next = acc_reg;
        end else if (y_inf) begin
            v4_next = prod3_reg;
        end else begin
            pass4_next = 1'b0;
        end
    end

    // Stage 5: add or subtract, renormalize, round
    logic [27:0]        sum5;
    logic [4:0]         lz5;
    logic [7:0]         lim5;
    logic [4:0]         sh5;
    logic [26:0]        n5;
    logic [25:0]        mm5;
    logic signed [11:0] e5;
    logic [31:0]        acc_next;

    always_comb begin
        sum5 = sub4_reg ? ({1'b0, mb4_reg} - {1'b0, ms4_reg})
                        : ({1'b0, mb4_reg} + {1'b0, ms4_reg});
        lz5  = lzc27(sum5[26:0]);
        lim5 = e4_reg - 8'd1;
        sh5  = ({3'b0, lz5} > lim5) ? lim5[4:0] : lz5;
        n5   = sum5[26:0] << sh5;
        if (sum5[27]) begin
            mm5 = {sum5[27:4], sum5[3], |sum5[2:0]};
            e5  = $signed({4'b0, e4_reg}) + 12'sd1;
        end else begin
            mm5 = {n5[26:3], n5[2], |n5[1:0]};
            e5  = $signed({4'b0, e4_reg}) - $signed({7'b0, sh5});
        end
        if (pass4_reg) begin
            acc_next = v4_reg;
        end else if (sum5 == 28'd0) begin
            acc_next = sub4_reg ? 32'd0 : {sgn4_reg, 31'b0};
        end else begin
            acc_next = round_pack(sgn4_reg, e5, mm5);
        end
    end

    // Hold control flags, advance the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_out_reg.f.valid <= 1'b0;
            fa_reg.valid        <= 1'b0;
            f1_reg.valid        <= 1'b0;
            f2_reg.valid        <= 1'b0;
            f3_reg.valid        <= 1'b0;
            f4_reg.valid        <= 1'b0;
            done_reg            <= 1'b0;
        end else begin
            tok_out_reg <= tok_in;
            fa_reg      <= tok_in.f;
            f1_reg      <= fa_reg;
            f2_reg      <= f1_reg;
            f3_reg      <= f2_reg;
            f4_reg      <= f3_reg;
            done_reg    <= f4_reg.valid && f4_reg.last;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (rload) begin
            rcol_reg[rrow] <= rdata;
        end
        a_reg     <= tok_in.lval;
        b_reg     <= rcol_reg[tok_in.k];
        sp1_reg   <= sp1_next;
        spv1_reg  <= spv1_next;
        sg1_reg   <= psign;
        ma1_reg   <= ma_raw << lza;
        mb1_reg   <= mb_raw << lzb;
        ea1_reg   <= $signed({2'b0, (|a_reg[30:23]) ? a_reg[30:23] : 8'd1})
                     - $signed({5'b0, lza});
        eb1_reg   <= $signed({2'b0, (|b_reg[30:23]) ? b_reg[30:23] : 8'd1})
                     - $signed({5'b0, lzb});
        sp2_reg   <= sp1_reg;
        spv2_reg  <= spv1_reg;
        sg2_reg   <= sg1_reg;
        p2_reg    <= {24'b0, ma1_reg} * {24'b0, mb1_reg};
        e2_reg    <= {{2{ea1_reg[9]}}, ea1_reg} + {{2{eb1_reg[9]}}, eb1_reg} - 12'sd127;
        prod3_reg <= sp2_reg ? spv2_reg : round_pack(sg2_reg, e3, mm3);
        pass4_reg <= pass4_next;
        v4_reg    <= v4_next;
        sub4_reg  <= big[31] ^ sml[31];
        sgn4_reg  <= big[31];
        e4_reg    <= ebig;
        mb4_reg   <= {|big[30:23], big[22:0], 3'b0};
        ms4_reg   <= msh;
        if (f4_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign tok_out   = tok_out_reg;
    assign result    = acc_reg;
    assign done_last = done_reg;

endmodule

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fmm_pkg::*;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int         RESET_CYCLES = 12;
    localparam int         SETTLE_CYCLES = 120;
    localparam int         HOLD_CYCLES = 400;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         RANDOM_PHASES = 4;
    localparam int         WORDS_PER_PHASE = 125;
    localparam logic [31:0] F_ONE = 32'h3F800000;
    localparam logic [31:0] F_ZERO = 32'h00000000;
    localparam logic [31:0] F_DEFAULT_NAN = 32'hFFC00000;

    typedef struct packed {
        logic [1:0]       act;
        logic [1:0]       row;
        logic [3:0][31:0] e;
        logic             ident;  // result is the identity, typed in
    } stim_t;

    typedef struct packed {
        logic [1:0]       out_row;
        logic [3:0][31:0] prod;
        logic             last_row;
    } prod_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [1:0]  s_row_index = '0;
    logic [31:0] s_elem0 = '0;
    logic [31:0] s_elem1 = '0;
    logic [31:0] s_elem2 = '0;
    logic [31:0] s_elem3 = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_out_row;
    logic [31:0] m_prod0;
    logic [31:0] m_prod1;
    logic [31:0] m_prod2;
    logic [31:0] m_prod3;
    logic        m_last_row;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    // Predictor state
    logic [31:0] left_rows [16];
    logic [31:0] right_rows [16];
    logic        affine_on = 1'b0;
    prod_row_t   pending_rows [$];

    int errors = 0;
    int cycles = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    fp_matrix_multiply_4x4_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_row_index (s_row_index),
        .s_elem0     (s_elem0),
        .s_elem1     (s_elem1),
        .s_elem2     (s_elem2),
        .s_elem3     (s_elem3),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_prod0     (m_prod0),
        .m_prod1     (m_prod1),
        .m_prod2     (m_prod2),
        .m_prod3     (m_prod3),
        .m_last_row  (m_last_row),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Single-precision helpers, round to nearest even, no flush to zero
    function automatic bit f_is_nan(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 0);
    endfunction

    function automatic bit f_is_inf(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 0);
    endfunction

    function automatic logic [63:0] f_mant(logic [31:0] x);
        return (x[30:23] == 0) ? {41'd0, x[22:0]} : {40'd0, 1'b1, x[22:0]};
    endfunction

    function automatic int f_exp(logic [31:0] x);
        return (x[30:23] == 0) ? 1 : int'(x[30:23]);
    endfunction

    // Round the value m * 2^e to single precision
    function automatic logic [31:0] round_pack(logic s, logic [63:0] m, int e);
        int          p;
        int          be;
        int          sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        if (m == 0) return {s, 31'd0};
        p = 63;
        while (!m[p]) p--;
        be = p + e + 127;
        sh = p - 23;
        if (be < 1) begin
            sh = sh + (1 - be);
            be = 0;
        end
        if (sh <= 0) begin
            q = m << (-sh);
        end else if (sh >= 64) begin
            q = 0;
        end else begin
            q = m >> sh;
            rem = m & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
        end
        if (be == 0) bits = q;
        else bits = (64'(be - 1) << 23) + q;
        if (bits >= 64'h7F800000) return {s, 8'hFF, 23'd0};
        return {s, bits[30:0]};
    endfunction

    function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (f_is_nan(a)) return a | 32'h00400000;
        if (f_is_nan(b)) return b | 32'h00400000;
        if (f_is_inf(a) || f_is_inf(b)) begin
            if (a[30:0] == 0 || b[30:0] == 0) return F_DEFAULT_NAN;
            return {s, 8'hFF, 23'd0};
        end
        return round_pack(s, f_mant(a) * f_mant(b), f_exp(a) + f_exp(b) - 300);
    endfunction

    function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [63:0] mh;
        logic [63:0] ml;
        int          d;
        int          e;
        if (f_is_nan(a)) return a | 32'h00400000;
        if (f_is_nan(b)) return b | 32'h00400000;
        if (f_is_inf(a) && f_is_inf(b) && (a[31] != b[31])) return F_DEFAULT_NAN;
        if (f_is_inf(a)) return a;
        if (f_is_inf(b)) return b;
        if (f_exp(a) >= f_exp(b)) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        d = f_exp(hi) - f_exp(lo);
        // far below the rounding point the small addend only acts as a sticky bit
        if (d <= 39) begin
            mh = f_mant(hi) << d;
            ml = f_mant(lo);
            e = f_exp(lo) - 150;
        end else begin
            mh = f_mant(hi) << 39;
            ml = (f_mant(lo) != 0) ? 64'd1 : 64'd0;
            e = f_exp(hi) - 150 - 39;
        end
        if (hi[31] == lo[31]) return round_pack(hi[31], mh + ml, e);
        if (mh > ml) return round_pack(hi[31], mh - ml, e);
        if (ml > mh) return round_pack(lo[31], ml - mh, e);
        return F_ZERO;
    endfunction

    // Work out the four product rows from the current stores and mode
    task automatic predict_product();
        prod_row_t   r;
        logic [31:0] acc;
        for (int i = 0; i < 4; i++) begin
            r.out_row = 2'(i);
            r.last_row = (i == 3);
            for (int j = 0; j < 4; j++) begin
                acc = f_mul(left_rows[i * 4], right_rows[j]);
                for (int k = 1; k < 4; k++) begin
                    if (!(affine_on && k == 3))
                        acc = f_add(acc, f_mul(left_rows[i * 4 + k], right_rows[k * 4 + j]));
                end
                if (affine_on && i == 3) acc = f_add(acc, right_rows[12 + j]);
                r.prod[j] = acc;
            end
            pending_rows.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_elem();
        logic [31:0] specials [10];
        int          r;
        specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                     32'h7FC00000, 32'h7F800001, 32'h00000001, 32'h807FFFFF,
                     32'h7F7FFFFF, 32'h3F800000};
        r = $urandom_range(0, 9);
        if (r == 0) return specials[$urandom_range(0, 9)];
        if (r == 1) return $urandom;
        return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
    endfunction

    // Offer one word, update the predictor on acceptance, then maybe idle a random gap
    task automatic send_word(stim_t w);
        int gap;
        s_valid <= 1'b1;
        s_action <= w.act;
        s_row_index <= w.row;
        s_elem0 <= w.e[0];
        s_elem1 <= w.e[1];
        s_elem2 <= w.e[2];
        s_elem3 <= w.e[3];
        do @(posedge aclk); while (!s_ready);
        if (w.act == ACT_LOAD_L || w.act == ACT_LOAD_R) begin
            for (int j = 0; j < 4; j++) begin
                if (w.act == ACT_LOAD_L) left_rows[w.row * 4 + j] = w.e[j];
                else right_rows[w.row * 4 + j] = w.e[j];
            end
        end else if (w.act == ACT_COMPUTE) begin
            if (w.ident) begin
                for (int i = 0; i < 4; i++) begin
                    pending_rows.push_back('{out_row: 2'(i), last_row: (i == 3),
                        prod: {(i == 3) ? F_ONE : F_ZERO, (i == 2) ? F_ONE : F_ZERO,
                               (i == 1) ? F_ONE : F_ZERO, (i == 0) ? F_ONE : F_ZERO}});
                end
            end else begin
                predict_product();
            end
        end
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        affine_on = v;
    endtask

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each delivered row with the oldest expected one
    always @(posedge aclk) begin
        prod_row_t exp_row;
        logic [3:0][31:0] got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_prod3, m_prod2, m_prod1, m_prod0};
            if (pending_rows.size() == 0) begin
                $error("unexpected product row %0d", m_out_row);
                errors++;
            end else begin
                exp_row = pending_rows.pop_front();
                if (m_out_row !== exp_row.out_row) begin
                    $error("out_row: expected %0d, actual %0d", exp_row.out_row, m_out_row);
                    errors++;
                end
                for (int j = 0; j < 4; j++) begin
                    if (got[j] !== exp_row.prod[j]) begin
                        $error("prod%0d: expected %h, actual %h", j, exp_row.prod[j], got[j]);
                        errors++;
                    end
                end
                if (m_last_row !== exp_row.last_row) begin
                    $error("last_row: expected %0d, actual %0d", exp_row.last_row, m_last_row);
                    errors++;
                end
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        stim_t dir_tab [22];
        stim_t w;
        int    r;
        int    sent;
        dir_tab = '{
            '{ACT_LOAD_L, 2'd0, {F_ZERO, F_ZERO, F_ZERO, F_ONE}, 1'b0},
            '{ACT_LOAD_L, 2'd1, {F_ZERO, F_ZERO, F_ONE, F_ZERO}, 1'b0},
            '{ACT_LOAD_L, 2'd2, {F_ZERO, F_ONE, F_ZERO, F_ZERO}, 1'b0},
            '{ACT_LOAD_L, 2'd3, {F_ONE, F_ZERO, F_ZERO, F_ZERO}, 1'b0},
            '{ACT_LOAD_R, 2'd0, {F_ZERO, F_ZERO, F_ZERO, F_ONE}, 1'b0},
            '{ACT_LOAD_R, 2'd1, {F_ZERO, F_ZERO, F_ONE, F_ZERO}, 1'b0},
            '{ACT_LOAD_R, 2'd2, {F_ZERO, F_ONE, F_ZERO, F_ZERO}, 1'b0},
            '{ACT_LOAD_R, 2'd3, {F_ONE, F_ZERO, F_ZERO, F_ZERO}, 1'b0},
            '{ACT_COMPUTE, 2'd0, {32'd0, 32'd0, 32'd0, 32'd0}, 1'b1},
            // dropped word with garbage, then identity again
            '{ACT_IGNORED, 2'd3, {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
              1'b0},
            '{ACT_COMPUTE, 2'd3, {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
              1'b1},
            // extremes: infinities, NaNs, signed zeros, denormals, largest values
            '{ACT_LOAD_L, 2'd0, {32'h00000001, 32'h7FFFFFFF, 32'h80000000, 32'h7F800000},
              1'b0},
            '{ACT_LOAD_L, 2'd1, {32'h807FFFFF, 32'h00800000, 32'hFF7FFFFF, 32'h7F7FFFFF},
              1'b0},
            '{ACT_LOAD_L, 2'd2, {32'h7FC00000, 32'h3F800000, 32'h00000000, 32'hFFFFFFFF},
              1'b0},
            '{ACT_LOAD_L, 2'd3, {32'hBF800000, 32'h40000000, 32'hFF800000, 32'h7F800001},
              1'b0},
            '{ACT_LOAD_R, 2'd0, {32'h00000001, 32'h3F800000, 32'h7F800000, 32'h00000000},
              1'b0},
            '{ACT_LOAD_R, 2'd1, {32'h7F7FFFFF, 32'h80000001, 32'h3F000000, 32'h7F7FFFFF},
              1'b0},
            '{ACT_LOAD_R, 2'd2, {32'h80000000, 32'h00000000, 32'hFF800000, 32'h3F800000},
              1'b0},
            '{ACT_LOAD_R, 2'd3, {32'h7F7FFFFF, 32'h807FFFFF, 32'h00000001, 32'hC0000000},
              1'b0},
            '{ACT_COMPUTE, 2'd1, {32'h12345678, 32'h9ABCDEF0, 32'h0, 32'hFFFFFFFF}, 1'b0},
            // cancellation and overflow in one row
            '{ACT_LOAD_L, 2'd2, {32'h7F7FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800000},
              1'b0},
            '{ACT_COMPUTE, 2'd2, {32'd0, 32'd0, 32'd0, 32'd0}, 1'b0}
        };

        // Hold reset, then set the mode explicitly
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b0);

        // Directed table
        foreach (dir_tab[n]) send_word(dir_tab[n]);
        s_valid <= 1'b0;
        drain();

        // Affine product on the extreme stores
        write_mode(1'b1);
        send_word('{ACT_COMPUTE, 2'd0, {32'd0, 32'd0, 32'd0, 32'd0}, 1'b0});
        s_valid <= 1'b0;
        drain();

        // Random phases, mode alternates then random
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_mode((ph < 2) ? 1'(ph) : 1'($urandom));
            if (ph == 1) hold_req = 1'b1;
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                if (sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                w.row = 2'($urandom);
                w.e = {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
                w.ident = 1'b0;
                if (r < 4) w.act = ACT_IGNORED;
                else if (r < 24) w.act = ACT_COMPUTE;
                else if (r < 62) w.act = ACT_LOAD_L;
                else w.act = ACT_LOAD_R;
                send_word(w);
                if (w.act != ACT_IGNORED) sent++;
            end
            no_idle = 1'b0;
            s_valid <= 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
